// ===== hw/rtl/gtq_pkg.sv =====
// gtq_pkg: shared types, codes and default sizes of the team queue
package gtq_pkg;

    // default sizes
    localparam int NUM_ELEMENTS_DEF  = 1024;
    localparam int NUM_TEAMS_DEF     = 32;
    localparam int POOL_CAPACITY_DEF = 256;

    // fixed field widths
    localparam int CMD_W    = 2;
    localparam int ELEM_W   = 10;
    localparam int TEAM_W   = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ASSIGN  = 2'd0,
        CMD_ENQUEUE = 2'd1,
        CMD_DEQUEUE = 2'd2,
        CMD_CLEAR   = 2'd3
    } gtq_command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_FULL       = 2'd2,
        ST_UNASSIGNED = 2'd3
    } gtq_status_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ELEM_W-1:0] element;
        logic [TEAM_W-1:0] team;
    } gtq_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ELEM_W-1:0]   out_element;
        logic [TEAM_W-1:0]   out_team;
    } gtq_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic sweep;
        logic enq_b;
        logic enq_c;
        logic deq_b;
        logic deq_c;
        logic deq_d;
        logic load_out;
    } gtq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic order_empty;
        logic enq_chain;
        logic sweep_last;
    } gtq_sts_t;

endpackage

// ===== hw/rtl/gtq_stream_if.sv =====
// gtq_stream_if: valid/ready channel carrying one payload
interface gtq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/gtq_ctrl.sv =====
// gtq_ctrl: sequencing state machine of the team queue
module gtq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic [1:0]        req_command,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output gtq_pkg::gtq_cmd_t cmd,
    input  gtq_pkg::gtq_sts_t sts
);
    import gtq_pkg::*;

    typedef enum logic [7:0] {
        S_SWEEP = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_ENQ_B = 8'b0000_0100,
        S_ENQ_C = 8'b0000_1000,
        S_DEQ_B = 8'b0001_0000,
        S_DEQ_C = 8'b0010_0000,
        S_DEQ_D = 8'b0100_0000,
        S_RESP  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   clear_pend_reg, clear_pend_next;
    logic   out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next      = state_reg;
        clear_pend_next = clear_pend_reg;
        cmd             = '0;
        case (state_reg)
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next      = clear_pend_reg ? S_RESP : S_IDLE;
                    clear_pend_next = 1'b0;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    case (req_command)
                        CMD_ASSIGN:  state_next = S_RESP;
                        CMD_ENQUEUE: state_next = S_ENQ_B;
                        CMD_DEQUEUE: state_next = sts.order_empty ? S_RESP : S_DEQ_B;
                        CMD_CLEAR:
                        begin
                            state_next      = S_SWEEP;
                            clear_pend_next = 1'b1;
                        end
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_ENQ_B:
            begin
                cmd.enq_b  = 1'b1;
                state_next = sts.enq_chain ? S_ENQ_C : S_RESP;
            end
            S_ENQ_C:
            begin
                cmd.enq_c  = 1'b1;
                state_next = S_RESP;
            end
            S_DEQ_B:
            begin
                cmd.deq_b  = 1'b1;
                state_next = S_DEQ_C;
            end
            S_DEQ_C:
            begin
                cmd.deq_c  = 1'b1;
                state_next = S_DEQ_D;
            end
            S_DEQ_D:
            begin
                cmd.deq_d  = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output slot occupancy
    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            clear_pend_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_pend_reg <= clear_pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

// ===== hw/rtl/gtq_dp.sv =====
// gtq_dp: memories, pointers and result registers of the team queue
module gtq_dp #(
    parameter int NUM_ELEMENTS  = gtq_pkg::NUM_ELEMENTS_DEF,
    parameter int NUM_TEAMS     = gtq_pkg::NUM_TEAMS_DEF,
    parameter int POOL_CAPACITY = gtq_pkg::POOL_CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  gtq_pkg::gtq_req_t req_data,
    input  gtq_pkg::gtq_cmd_t cmd,
    output gtq_pkg::gtq_sts_t sts,
    output gtq_pkg::gtq_rsp_t rsp_data
);
    import gtq_pkg::*;

    localparam int EW        = $clog2(NUM_ELEMENTS);
    localparam int TW        = $clog2(NUM_TEAMS);
    localparam int NW        = $clog2(POOL_CAPACITY);
    localparam int UW        = NW + 1;
    localparam int CW        = TW + 1;
    localparam int SWEEP_LEN = (NUM_ELEMENTS > POOL_CAPACITY) ? NUM_ELEMENTS : POOL_CAPACITY;
    localparam int SW        = $clog2(SWEEP_LEN);

    // memories
    logic [TW:0]       map_mem   [NUM_ELEMENTS];
    logic [ELEM_W-1:0] value_mem [POOL_CAPACITY];
    logic [NW-1:0]     link_mem  [POOL_CAPACITY];
    logic [NW-1:0]     head_mem  [NUM_TEAMS];
    logic [NW-1:0]     tail_mem  [NUM_TEAMS];
    logic [TW-1:0]     ring_mem  [NUM_TEAMS];

    // registered read data
    logic [TW:0]       map_rd_reg;
    logic [ELEM_W-1:0] value_rd_reg;
    logic [NW-1:0]     link_rd_reg;
    logic [NW-1:0]     head_rd_reg;
    logic [NW-1:0]     tail_rd_reg;
    logic [TW-1:0]     ring_rd_reg;

    // control state
    logic [NW-1:0]        free_head_reg;
    logic [UW-1:0]        used_reg;
    logic [NUM_TEAMS-1:0] active_reg;
    logic [TW-1:0]        order_rd_reg;
    logic [TW-1:0]        order_wr_reg;
    logic [CW-1:0]        order_cnt_reg;
    logic [SW-1:0]        sweep_reg;

    // per-request payload
    logic [ELEM_W-1:0] elem_reg;
    logic              elem_ok_reg;
    logic [TW-1:0]     tm_reg;
    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     h_reg;
    gtq_status_t       res_status_reg;
    logic [ELEM_W-1:0] res_elem_reg;
    logic [TW-1:0]     res_team_reg;
    gtq_rsp_t          out_reg;

    // decoded request and enqueue checks
    logic          acc_assign, acc_enq, acc_deq, acc_clear;
    logic          map_ok, pool_full, enq_ok, tm_active, deq_last;
    logic [TW-1:0] tm_map;
    logic [TW-1:0] order_rd_inc, order_wr_inc;
    logic [NW-1:0] sweep_link;

    assign acc_assign = cmd.accept && (req_data.command == CMD_ASSIGN);
    assign acc_enq    = cmd.accept && (req_data.command == CMD_ENQUEUE);
    assign acc_deq    = cmd.accept && (req_data.command == CMD_DEQUEUE);
    assign acc_clear  = cmd.accept && (req_data.command == CMD_CLEAR);

    assign tm_map     = map_rd_reg[TW-1:0];
    assign map_ok     = elem_ok_reg && map_rd_reg[TW];
    assign pool_full  = (used_reg >= UW'(POOL_CAPACITY));
    assign tm_active  = active_reg[tm_map];
    assign enq_ok     = map_ok && !pool_full;
    assign deq_last   = (h_reg == tail_rd_reg);

    assign order_rd_inc = (order_rd_reg == TW'(NUM_TEAMS - 1)) ? '0 : order_rd_reg + 1'b1;
    assign order_wr_inc = (order_wr_reg == TW'(NUM_TEAMS - 1)) ? '0 : order_wr_reg + 1'b1;
    assign sweep_link   = (sweep_reg[NW-1:0] == NW'(POOL_CAPACITY - 1)) ? '0
                        : sweep_reg[NW-1:0] + 1'b1;

    assign sts.order_empty = (order_cnt_reg == '0);
    assign sts.enq_chain   = enq_ok && tm_active;
    assign sts.sweep_last  = (sweep_reg == SW'(SWEEP_LEN - 1));

    // element map: sweep clear, assign write, enqueue lookup
    always_ff @(posedge clk)
    begin
        if (cmd.sweep && (int'(sweep_reg) < NUM_ELEMENTS))
            map_mem[sweep_reg[EW-1:0]] <= '0;
        else if (acc_assign && (int'(req_data.element) < NUM_ELEMENTS)
                 && (int'(req_data.team) < NUM_TEAMS))
            map_mem[EW'(req_data.element)] <= {1'b1, TW'(req_data.team)};
        if (acc_enq)
            map_rd_reg <= map_mem[EW'(req_data.element)];
    end

    // node values
    always_ff @(posedge clk)
    begin
        if (cmd.enq_b && enq_ok)
            value_mem[free_head_reg] <= elem_reg;
        if (cmd.deq_c)
            value_rd_reg <= value_mem[head_rd_reg];
    end

    // node links: free list rebuild, list append, node release
    always_ff @(posedge clk)
    begin
        if (cmd.sweep && (int'(sweep_reg) < POOL_CAPACITY))
            link_mem[sweep_reg[NW-1:0]] <= sweep_link;
        else if (cmd.enq_c)
            link_mem[tail_rd_reg] <= n_reg;
        else if (cmd.deq_d)
            link_mem[h_reg] <= free_head_reg;
        if (acc_enq)
            link_rd_reg <= link_mem[free_head_reg];
        else if (cmd.deq_c)
            link_rd_reg <= link_mem[head_rd_reg];
    end

    // team head pointers
    always_ff @(posedge clk)
    begin
        if (cmd.enq_b && enq_ok && !tm_active)
            head_mem[tm_map] <= free_head_reg;
        else if (cmd.deq_d && !deq_last)
            head_mem[tm_reg] <= link_rd_reg;
        if (cmd.deq_b)
            head_rd_reg <= head_mem[ring_rd_reg];
    end

    // team tail pointers
    always_ff @(posedge clk)
    begin
        if (cmd.enq_b && enq_ok && !tm_active)
            tail_mem[tm_map] <= free_head_reg;
        else if (cmd.enq_c)
            tail_mem[tm_reg] <= n_reg;
        if (cmd.enq_b)
            tail_rd_reg <= tail_mem[tm_map];
        else if (cmd.deq_b)
            tail_rd_reg <= tail_mem[ring_rd_reg];
    end

    // order ring of active teams
    always_ff @(posedge clk)
    begin
        if (cmd.enq_b && enq_ok && !tm_active)
            ring_mem[order_wr_reg] <= tm_map;
        if (acc_deq)
            ring_rd_reg <= ring_mem[order_rd_reg];
    end

    // pool, team and ring bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            used_reg      <= '0;
            active_reg    <= '0;
            order_rd_reg  <= '0;
            order_wr_reg  <= '0;
            order_cnt_reg <= '0;
            sweep_reg     <= '0;
        end
        else if (acc_clear)
        begin
            free_head_reg <= '0;
            used_reg      <= '0;
            active_reg    <= '0;
            order_rd_reg  <= '0;
            order_wr_reg  <= '0;
            order_cnt_reg <= '0;
            sweep_reg     <= '0;
        end
        else if (cmd.sweep)
        begin
            if (!sts.sweep_last)
                sweep_reg <= sweep_reg + 1'b1;
        end
        else if (cmd.enq_b && enq_ok)
        begin
            free_head_reg <= link_rd_reg;
            used_reg      <= used_reg + 1'b1;
            if (!tm_active)
            begin
                active_reg[tm_map] <= 1'b1;
                order_wr_reg       <= order_wr_inc;
                order_cnt_reg      <= order_cnt_reg + 1'b1;
            end
        end
        else if (cmd.deq_d)
        begin
            free_head_reg <= h_reg;
            if (used_reg != '0)
                used_reg <= used_reg - 1'b1;
            if (deq_last)
            begin
                active_reg[tm_reg] <= 1'b0;
                order_rd_reg       <= order_rd_inc;
                order_cnt_reg      <= order_cnt_reg - 1'b1;
            end
        end
    end

    // request payload and result staging
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            elem_reg       <= req_data.element;
            elem_ok_reg    <= (int'(req_data.element) < NUM_ELEMENTS);
            res_status_reg <= (acc_deq && sts.order_empty) ? ST_EMPTY : ST_OK;
            res_elem_reg   <= '0;
            res_team_reg   <= '0;
        end
        if (cmd.enq_b)
        begin
            tm_reg         <= tm_map;
            n_reg          <= free_head_reg;
            res_status_reg <= !map_ok ? ST_UNASSIGNED : (pool_full ? ST_FULL : ST_OK);
        end
        if (cmd.deq_b)
            tm_reg <= ring_rd_reg;
        if (cmd.deq_c)
            h_reg <= head_rd_reg;
        if (cmd.deq_d)
        begin
            res_elem_reg <= value_rd_reg;
            res_team_reg <= tm_reg;
        end
        if (cmd.load_out)
        begin
            out_reg.status      <= res_status_reg;
            out_reg.out_element <= res_elem_reg;
            out_reg.out_team    <= TEAM_W'(res_team_reg);
        end
    end

    assign rsp_data = out_reg;

endmodule

// ===== hw/rtl/grouped_team_queue.sv =====
// grouped_team_queue: team queue top level, controller plus datapath
//
//  channel | dir | payload                          | moves
//  req     | in  | command, element, team           | one request per command
//  rsp     | out | status, out_element, out_team    | one result per request
//
// per request: assign and failed dequeue go straight to the response state; enqueue
// passes ENQ_B (and ENQ_C when appended to a busy team), dequeue DEQ_B, DEQ_C, DEQ_D;
// the chain of dependent synchronous-RAM reads sets these states. clear sweeps
// max(NUM_ELEMENTS, POOL_CAPACITY) entries, rewriting the element map and free-list
// links one entry a cycle; the same sweep runs after reset, req.ready low throughout.
// a finished result waits in the output register; the next request is taken meanwhile.
module grouped_team_queue #(
    parameter int NUM_ELEMENTS  = gtq_pkg::NUM_ELEMENTS_DEF,
    parameter int NUM_TEAMS     = gtq_pkg::NUM_TEAMS_DEF,
    parameter int POOL_CAPACITY = gtq_pkg::POOL_CAPACITY_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    gtq_stream_if.sink   req,
    gtq_stream_if.source rsp
);
    import gtq_pkg::*;

    gtq_cmd_t cmd;
    gtq_sts_t sts;
    gtq_req_t req_data;
    gtq_rsp_t rsp_data;

    assign req_data    = req.payload;
    assign rsp.payload = rsp_data;

    // sequencing
    gtq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req.valid),
        .req_command (req_data.command),
        .req_ready   (req.ready),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    // storage and arithmetic
    gtq_dp #(
        .NUM_ELEMENTS  (NUM_ELEMENTS),
        .NUM_TEAMS     (NUM_TEAMS),
        .POOL_CAPACITY (POOL_CAPACITY)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp_data (rsp_data)
    );

endmodule
